// ===== rtl/core/gwpf_pkg.sv =====
`default_nettype none
package gwpf_pkg;

	localparam int ROW_BITS    = 6;
	localparam int COL_BITS    = 6;
	localparam int CELL_BITS   = ROW_BITS + COL_BITS;
	localparam int NUM_CELLS   = 1 << CELL_BITS;
	localparam int DIM_BITS    = 7;
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int HEIGHT_BITS = 16;
	localparam int LEVEL_BITS  = 12;
	localparam int COUNT_BITS  = 13;
	localparam int DIR_BITS    = 3;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_FIND  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_REACHED  = 2'd0,
		STAT_MISMATCH = 2'd1,
		STAT_UNREACH  = 2'd2,
		STAT_BEYOND   = 2'd3
	} stat_t;

	typedef enum logic {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD_WAIT,
		S_HS,
		S_HE,
		S_CLR,
		S_SEED,
		S_LVL,
		S_FRD,
		S_FWT,
		S_NB,
		S_HWT,
		S_WWT,
		S_BT_INIT,
		S_BT_NB,
		S_BT_WWT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                ok;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
	} nbr_t;

endpackage
`default_nettype wire

// ===== rtl/core/gwpf_nbr.sv =====
`default_nettype none
module gwpf_nbr (
	input  wire logic [gwpf_pkg::ROW_BITS-1:0] row,
	input  wire logic [gwpf_pkg::COL_BITS-1:0] col,
	input  wire logic [gwpf_pkg::DIR_BITS-1:0] dir,
	input  wire logic [gwpf_pkg::DIM_BITS-1:0] rows_lim,
	input  wire logic [gwpf_pkg::DIM_BITS-1:0] cols_lim,
	output gwpf_pkg::nbr_t                     nbr
);
	import gwpf_pkg::*;

	logic [DIM_BITS:0] dr;
	logic [DIM_BITS:0] dc;
	logic [DIM_BITS:0] ra;
	logic [DIM_BITS:0] ca;

	// table order: left, up, right, down, up-left, up-right, down-right, down-left
	always_comb begin
		case (dir)
			3'd0: begin dr = '0; dc = '1; end
			3'd1: begin dr = '1; dc = '0; end
			3'd2: begin dr = '0; dc = (DIM_BITS+1)'(1); end
			3'd3: begin dr = (DIM_BITS+1)'(1); dc = '0; end
			3'd4: begin dr = '1; dc = '1; end
			3'd5: begin dr = '1; dc = (DIM_BITS+1)'(1); end
			3'd6: begin dr = (DIM_BITS+1)'(1); dc = (DIM_BITS+1)'(1); end
			default: begin dr = (DIM_BITS+1)'(1); dc = '1; end
		endcase
		ra = (DIM_BITS+1)'(row) + dr;
		ca = (DIM_BITS+1)'(col) + dc;
		nbr.ok  = !ra[DIM_BITS] && !ca[DIM_BITS] &&
			(ra[DIM_BITS-1:0] < rows_lim) && (ca[DIM_BITS-1:0] < cols_lim);
		nbr.row = ra[ROW_BITS-1:0];
		nbr.col = ca[COL_BITS-1:0];
	end

endmodule
`default_nettype wire

// ===== rtl/core/grid_wave_path_finder.sv =====
`default_nettype none
// Lee wave router over a 64 x 64 height grid with 8-neighbour moves. A height write answers
// in the next cycle, a path read after the path memory read and the output register. A find
// first checks that start and goal lie on the grid and share a height, then sweeps the wave
// store clear (the clearing pass), then expands the wave one neighbour at a time through a
// single shared neighbour unit and height, wave and frontier memories with one read and one
// write port each. The input stalls for the whole find; configuration writes are always taken.
module grid_wave_path_finder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic                               cfg_index,
	input  wire logic [gwpf_pkg::DIM_BITS-1:0]      cfg_data,
	input  wire logic                               in_valid,
	output      logic                               in_stall,
	input  wire logic [1:0]                         cmd,
	input  wire logic [gwpf_pkg::ROW_BITS-1:0]      cell_row,
	input  wire logic [gwpf_pkg::COL_BITS-1:0]      cell_col,
	input  wire logic [gwpf_pkg::ROW_BITS-1:0]      goal_row,
	input  wire logic [gwpf_pkg::COL_BITS-1:0]      goal_col,
	input  wire logic [15:0]                        height_level,
	input  wire logic [11:0]                        step_index,
	output      logic                               out_valid,
	input  wire logic                               out_stall,
	output      logic [1:0]                         status,
	output      logic [gwpf_pkg::COUNT_BITS-1:0]    path_length,
	output      logic [gwpf_pkg::ROW_BITS-1:0]      path_row,
	output      logic [gwpf_pkg::COL_BITS-1:0]      path_col
);
	import gwpf_pkg::*;

	localparam int WAVE_W = LEVEL_BITS + 1;

	state_t state_q, state_d;

	logic [DIM_BITS-1:0] rows_cfg_q, cols_cfg_q, nr, nc;

	logic [ROW_BITS-1:0] sr_q, er_q, cur_r_q;
	logic [COL_BITS-1:0] sc_q, ec_q, cur_c_q;
	logic [HEIGHT_BITS-1:0] hs_q;
	logic [LEVEL_BITS-1:0] level_q, pos_q;
	logic [COUNT_BITS-1:0] curn_q, nextn_q, k_q, path_count_q;
	logic [CELL_BITS-1:0] clr_q;
	logic [DIR_BITS-1:0] dir_q;
	logic [3:0] lvl_q;
	logic fbank_q;
	stat_t last_status_q;

	logic out_valid_q;
	logic [1:0] status_q;
	logic [COUNT_BITS-1:0] length_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;

	// memories
	logic [HEIGHT_BITS-1:0] height_mem [NUM_CELLS];
	logic [WAVE_W-1:0]      wave_mem   [NUM_CELLS];
	logic [CELL_BITS-1:0]   front_mem  [2*NUM_CELLS];
	logic [CELL_BITS-1:0]   path_mem   [NUM_CELLS];
	logic [HEIGHT_BITS-1:0] hrd_q;
	logic [WAVE_W-1:0]      wrd_q;
	logic [CELL_BITS-1:0]   frd_q, prd_q;

	logic h_we, w_we, f_we, p_we;
	logic [CELL_BITS-1:0] h_waddr, h_raddr, w_waddr, w_raddr, p_waddr, p_raddr;
	logic [CELL_BITS:0] f_waddr, f_raddr;
	logic [HEIGHT_BITS-1:0] h_wdata;
	logic [WAVE_W-1:0] w_wdata;
	logic [CELL_BITS-1:0] f_wdata, p_wdata;

	logic in_acc;
	nbr_t nb;
	logic [CELL_BITS-1:0] nb_idx, start_idx, goal_idx;
	logic last_dir, last_cell, cand;

	// control strobes to the datapath
	logic fin_we;
	stat_t fin_status;
	logic [COUNT_BITS-1:0] fin_count;
	logic dir_inc, dir_clr, k_inc, lvl_adv, lvl_we, lvl_val, enq, bt_step;
	logic out_load;
	logic [1:0] out_status_d;
	logic [ROW_BITS-1:0] out_row_d;
	logic [COL_BITS-1:0] out_col_d;

	function automatic logic diag_ok(logic [DIR_BITS-1:0] d, logic [3:0] lv);
		case (d)
			3'd4: diag_ok = lv[0] && lv[1];
			3'd5: diag_ok = lv[1] && lv[2];
			3'd6: diag_ok = lv[2] && lv[3];
			3'd7: diag_ok = lv[0] && lv[3];
			default: diag_ok = 1'b1;
		endcase
	endfunction

	assign nr = (rows_cfg_q == '0) ? DIM_BITS'(1) :
		(rows_cfg_q > DIM_BITS'(MAX_ROWS)) ? DIM_BITS'(MAX_ROWS) : rows_cfg_q;
	assign nc = (cols_cfg_q == '0) ? DIM_BITS'(1) :
		(cols_cfg_q > DIM_BITS'(MAX_COLS)) ? DIM_BITS'(MAX_COLS) : cols_cfg_q;

	gwpf_nbr u_nbr (
		.row      (cur_r_q),
		.col      (cur_c_q),
		.dir      (dir_q),
		.rows_lim (nr),
		.cols_lim (nc),
		.nbr      (nb)
	);

	assign nb_idx    = {nb.row, nb.col};
	assign start_idx = {sr_q, sc_q};
	assign goal_idx  = {er_q, ec_q};
	assign last_dir  = (dir_q == '1);
	assign last_cell = ((k_q + COUNT_BITS'(1)) == curn_q);
	assign cand      = (hrd_q == hs_q) && diag_ok(dir_q, lvl_q);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		h_we = 1'b0; w_we = 1'b0; f_we = 1'b0; p_we = 1'b0;
		h_waddr = {cell_row, cell_col};
		h_wdata = height_level[HEIGHT_BITS-1:0];
		h_raddr = nb_idx;
		w_waddr = nb_idx;
		w_wdata = {1'b1, level_q};
		w_raddr = nb_idx;
		f_waddr = {!fbank_q, nextn_q[CELL_BITS-1:0]};
		f_wdata = nb_idx;
		f_raddr = {fbank_q, k_q[CELL_BITS-1:0]};
		p_waddr = '0;
		p_wdata = start_idx;
		p_raddr = step_index;
		fin_we = 1'b0; fin_status = STAT_REACHED; fin_count = COUNT_BITS'(1);
		dir_inc = 1'b0; dir_clr = 1'b0; k_inc = 1'b0; lvl_adv = 1'b0;
		lvl_we = 1'b0; lvl_val = 1'b0; enq = 1'b0; bt_step = 1'b0;
		out_load = 1'b0;
		out_status_d = last_status_q;
		out_row_d = '0;
		out_col_d = '0;

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (cmd_t'(cmd))
						CMD_WRITE: begin
							h_we = 1'b1;
							out_load = 1'b1;
						end
						CMD_FIND: begin
							if ({1'b0, cell_row} >= nr || {1'b0, cell_col} >= nc ||
								{1'b0, goal_row} >= nr || {1'b0, goal_col} >= nc) begin
								p_we = 1'b1;
								p_wdata = {cell_row, cell_col};
								fin_we = 1'b1;
								fin_status = STAT_UNREACH;
								state_d = S_DONE;
							end else begin
								h_raddr = {cell_row, cell_col};
								state_d = S_HS;
							end
						end
						CMD_READ: begin
							if (COUNT_BITS'(step_index) < path_count_q) begin
								state_d = S_RD_WAIT;
							end else begin
								out_load = 1'b1;
								out_status_d = STAT_BEYOND;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			S_RD_WAIT: begin
				out_load = 1'b1;
				out_row_d = prd_q[CELL_BITS-1:COL_BITS];
				out_col_d = prd_q[COL_BITS-1:0];
				state_d = S_IDLE;
			end
			S_HS: begin
				h_raddr = goal_idx;
				state_d = S_HE;
			end
			S_HE: begin
				if (hrd_q != hs_q) begin
					fin_we = 1'b1;
					fin_status = STAT_MISMATCH;
					fin_count = '0;
					state_d = S_DONE;
				end else if (start_idx == goal_idx) begin
					p_we = 1'b1;
					fin_we = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_CLR;
				end
			end
			S_CLR: begin
				w_we = 1'b1;
				w_waddr = clr_q;
				w_wdata = '0;
				if (clr_q == '1) begin
					state_d = S_SEED;
				end
			end
			S_SEED: begin
				w_we = 1'b1;
				w_waddr = start_idx;
				w_wdata = {1'b1, {LEVEL_BITS{1'b0}}};
				f_we = 1'b1;
				f_waddr = {1'b0, {CELL_BITS{1'b0}}};
				f_wdata = start_idx;
				state_d = S_LVL;
			end
			S_LVL: begin
				if (curn_q == '0) begin
					p_we = 1'b1;
					fin_we = 1'b1;
					fin_status = STAT_UNREACH;
					state_d = S_DONE;
				end else begin
					state_d = S_FRD;
				end
			end
			S_FRD: begin
				state_d = S_FWT;
			end
			S_FWT: begin
				dir_clr = 1'b1;
				state_d = S_NB;
			end
			S_NB, S_HWT, S_WWT: begin
				// one neighbour check; the shared tail steps direction, cell and level
				logic advance;
				advance = 1'b0;
				if (state_q == S_NB) begin
					if (nb.ok) begin
						state_d = S_HWT;
					end else begin
						lvl_we = 1'b1;
						advance = 1'b1;
					end
				end else if (state_q == S_HWT) begin
					lvl_we = 1'b1;
					lvl_val = (hrd_q == hs_q);
					if (cand) begin
						state_d = S_WWT;
					end else begin
						advance = 1'b1;
					end
				end else begin
					if (!wrd_q[LEVEL_BITS]) begin
						w_we = 1'b1;
						f_we = 1'b1;
						enq = 1'b1;
						if (nb_idx == goal_idx) begin
							state_d = S_BT_INIT;
						end else begin
							advance = 1'b1;
						end
					end else begin
						advance = 1'b1;
					end
				end
				if (advance) begin
					if (!last_dir) begin
						dir_inc = 1'b1;
						state_d = S_NB;
					end else if (!last_cell) begin
						k_inc = 1'b1;
						state_d = S_FRD;
					end else begin
						lvl_adv = 1'b1;
						state_d = S_LVL;
					end
				end
			end
			S_BT_INIT: begin
				p_we = 1'b1;
				p_waddr = level_q;
				p_wdata = goal_idx;
				fin_we = 1'b1;
				fin_count = COUNT_BITS'(level_q) + COUNT_BITS'(1);
				dir_clr = 1'b1;
				state_d = S_BT_NB;
			end
			S_BT_NB: begin
				if (pos_q == '0) begin
					state_d = S_DONE;
				end else if (nb.ok) begin
					state_d = S_BT_WWT;
				end else if (last_dir) begin
					state_d = S_DONE;
				end else begin
					dir_inc = 1'b1;
				end
			end
			S_BT_WWT: begin
				if (wrd_q[LEVEL_BITS] && wrd_q[LEVEL_BITS-1:0] == pos_q - LEVEL_BITS'(1)) begin
					p_we = 1'b1;
					p_waddr = pos_q - LEVEL_BITS'(1);
					p_wdata = nb_idx;
					bt_step = 1'b1;
					dir_clr = 1'b1;
					state_d = S_BT_NB;
				end else if (last_dir) begin
					state_d = S_DONE;
				end else begin
					dir_inc = 1'b1;
					state_d = S_BT_NB;
				end
			end
			S_DONE: begin
				out_load = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memories, read data registered
	always_ff @(posedge clk) begin
		if (h_we) begin
			height_mem[h_waddr] <= h_wdata;
		end
		hrd_q <= height_mem[h_raddr];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wave_mem[w_waddr] <= w_wdata;
		end
		wrd_q <= wave_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			front_mem[f_waddr] <= f_wdata;
		end
		frd_q <= front_mem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			path_mem[p_waddr] <= p_wdata;
		end
		prd_q <= path_mem[p_raddr];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= DIM_BITS'(MAX_ROWS);
			cols_cfg_q <= DIM_BITS'(MAX_COLS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROWS: rows_cfg_q <= cfg_data;
				CFG_COLS: cols_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// find datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			sr_q <= cell_row;
			sc_q <= cell_col;
			er_q <= goal_row;
			ec_q <= goal_col;
		end
		if (state_q == S_HS) begin
			hs_q <= hrd_q;
		end
		if (state_q == S_HE) begin
			clr_q <= '0;
		end else if (state_q == S_CLR) begin
			clr_q <= clr_q + CELL_BITS'(1);
		end
		if (state_q == S_SEED) begin
			fbank_q <= 1'b0;
			curn_q  <= COUNT_BITS'(1);
			nextn_q <= '0;
			k_q     <= '0;
			level_q <= LEVEL_BITS'(1);
		end else begin
			if (k_inc) begin
				k_q <= k_q + COUNT_BITS'(1);
			end
			// a cell queued on the last check of a level still counts for the next one
			if (lvl_adv) begin
				fbank_q <= !fbank_q;
				curn_q  <= enq ? nextn_q + COUNT_BITS'(1) : nextn_q;
				nextn_q <= '0;
				k_q     <= '0;
				level_q <= level_q + LEVEL_BITS'(1);
			end else if (enq) begin
				nextn_q <= nextn_q + COUNT_BITS'(1);
			end
		end
		if (state_q == S_FWT) begin
			cur_r_q <= frd_q[CELL_BITS-1:COL_BITS];
			cur_c_q <= frd_q[COL_BITS-1:0];
		end else if (state_q == S_BT_INIT) begin
			cur_r_q <= er_q;
			cur_c_q <= ec_q;
			pos_q   <= level_q;
		end else if (bt_step) begin
			cur_r_q <= nb.row;
			cur_c_q <= nb.col;
			pos_q   <= pos_q - LEVEL_BITS'(1);
		end
		if (dir_clr) begin
			dir_q <= '0;
		end else if (dir_inc) begin
			dir_q <= dir_q + DIR_BITS'(1);
		end
		// orthogonal level flags feed the diagonal check
		if (lvl_we && !dir_q[DIR_BITS-1]) begin
			lvl_q[dir_q[1:0]] <= lvl_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_count_q  <= '0;
			last_status_q <= STAT_MISMATCH;
			out_valid_q   <= 1'b0;
		end else begin
			if (fin_we) begin
				path_count_q  <= fin_count;
				last_status_q <= fin_status;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= out_status_d;
			length_q <= path_count_q;
			row_q    <= out_row_d;
			col_q    <= out_col_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign path_length = length_q;
	assign path_row    = row_q;
	assign path_col    = col_q;

	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		enq |-> nextn_q < COUNT_BITS'(NUM_CELLS))
		else $error("frontier overflow");

	a_bt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BT_NB) |-> pos_q <= level_q)
		else $error("backtrack position beyond wave level");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten before transfer");

	a_status_kept: assert property (@(posedge clk) disable iff (!arst_n)
		fin_we |=> last_status_q != STAT_BEYOND)
		else $error("stored status out of range");

endmodule
`default_nettype wire
